// ----- rtl/core/stt_pkg.sv -----
package stt_pkg;

  // Default widths of the natural accumulator and the line counter.
  localparam int unsigned VALUE_WIDTH_DEF = 64;
  localparam int unsigned LINE_WIDTH_DEF  = 32;

  // Result queue between the scanner and the output port.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Scanner modes.
  typedef enum logic [3:0] {
    MODE_START  = 4'd0,
    MODE_NUMBER = 4'd1,
    MODE_IDENT  = 4'd2,
    MODE_STRING = 4'd3,
    MODE_ESCAPE = 4'd4,
    MODE_DASH   = 4'd5,
    MODE_HASH   = 4'd6,
    MODE_SLASH  = 4'd7,
    MODE_LINE   = 4'd8,
    MODE_BLOCK  = 4'd9
  } scan_mode_e;

  // Token kinds.
  localparam logic [4:0] KIND_DONE      = 5'd0;
  localparam logic [4:0] KIND_DOT       = 5'd1;
  localparam logic [4:0] KIND_SEMI      = 5'd2;
  localparam logic [4:0] KIND_LPAREN    = 5'd3;
  localparam logic [4:0] KIND_RPAREN    = 5'd4;
  localparam logic [4:0] KIND_COMMA     = 5'd5;
  localparam logic [4:0] KIND_COLON     = 5'd6;
  localparam logic [4:0] KIND_QUESTION  = 5'd7;
  localparam logic [4:0] KIND_BAR       = 5'd8;
  localparam logic [4:0] KIND_EQUALS    = 5'd9;
  localparam logic [4:0] KIND_ARROW     = 5'd10;
  localparam logic [4:0] KIND_DOLLAR    = 5'd11;
  localparam logic [4:0] KIND_AMP       = 5'd12;
  localparam logic [4:0] KIND_KW_FIRST  = 5'd13;
  localparam logic [4:0] KIND_STRING    = 5'd21;
  localparam logic [4:0] KIND_NATURAL   = 5'd22;
  localparam logic [4:0] KIND_IDENT     = 5'd23;
  localparam logic [4:0] KIND_TEXT_BYTE = 5'd24;

  // Error codes.
  localparam logic [2:0] ERR_NONE          = 3'd0;
  localparam logic [2:0] ERR_UNEXPECTED    = 3'd1;
  localparam logic [2:0] ERR_BAD_ESCAPE    = 3'd2;
  localparam logic [2:0] ERR_OPEN_STRING   = 3'd3;
  localparam logic [2:0] ERR_OPEN_COMMENT  = 3'd4;

  // Keyword spellings, one byte per position, padded with zeros.
  localparam int unsigned KW_COUNT = 8;
  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{"l", "e", "t", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"f", "n", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"p", "i", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"s", "g", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"a", "d", "t", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"s", "e", "l", "f", 8'd0, 8'd0, 8'd0, 8'd0},
    '{"u", "n", "i", "v", "e", "r", "s", "e"},
    '{"d", "e", "c", "l", "a", "r", "e", 8'd0}
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd2, 4'd2, 4'd2, 4'd3, 4'd4, 4'd8, 4'd7
  };

  // One result item as it travels to the output port.
  typedef struct packed {
    logic [4:0]  token_kind;
    logic [7:0]  text_byte;
    logic [63:0] number_value;
    logic        number_overflow;
    logic [31:0] line_number;
    logic [2:0]  error_code;
    logic        last;
  } result_t;

  // True when keyword k can take byte c at position pos, given that the
  // bytes so far spelt the prefix of keyword cand.
  function automatic logic kw_match(logic [2:0] k, logic [2:0] cand, logic [2:0] pos,
                                    logic [7:0] c);
    logic ok;
    ok = ({1'b0, pos} < KW_LEN[k]) && (KW_TEXT[k][pos] == c);
    for (int i = 0; i < 7; i++) begin
      if ((3'(i) < pos) && (KW_TEXT[k][i] != KW_TEXT[cand][i])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

// ----- rtl/core/stt_scanner.sv -----
module stt_scanner #(
  parameter int unsigned VALUE_WIDTH = stt_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned LINE_WIDTH  = stt_pkg::LINE_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic             eot_i,
  output logic             res_a_valid_o,
  output stt_pkg::result_t res_a_o,
  output logic             res_b_valid_o,
  output stt_pkg::result_t res_b_o
);

  localparam logic [LINE_WIDTH-1:0] LineMax = '1;

  stt_pkg::scan_mode_e    mode_q, mode_d;
  logic [2:0]             cand_q, cand_d;
  logic [3:0]             pos_q, pos_d;
  logic                   star_q, star_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic                   ovf_q, ovf_d;
  logic [LINE_WIDTH-1:0]  lc_q, lc_d;
  logic                   halt_q, halt_d;

  logic [LINE_WIDTH-1:0]  lc_inc, ln_now, ln_inc;
  logic [VALUE_WIDTH+3:0] acc_wide;
  logic [VALUE_WIDTH+3:0] acc_ext;

  // Start-of-token decode.
  stt_pkg::scan_mode_e st_mode;
  logic                st_emit;
  logic [4:0]          st_kind;
  logic [7:0]          st_byte;
  logic [2:0]          st_err;
  logic                st_fail;
  logic                st_line;
  logic                st_num;
  logic                st_hash;

  // Keyword search.
  logic       kw_hit;
  logic [2:0] kw_idx;
  logic       kw_done;

  // Scratch for the main step.
  logic       do_start;
  logic       start_in_b;
  logic       a_v, b_v;
  stt_pkg::result_t ra, rb;

  // Saturating line counts; the reported line is the count plus one.
  assign lc_inc = (lc_q == LineMax) ? lc_q : lc_q + LINE_WIDTH'(1);
  assign ln_now = lc_inc;
  assign ln_inc = (lc_inc == LineMax) ? lc_inc : lc_inc + LINE_WIDTH'(1);

  // Multiply by ten and add the digit; any bit above the value width is overflow.
  assign acc_ext  = {4'b0000, acc_q};
  assign acc_wide = (acc_ext << 3) + (acc_ext << 1) + (VALUE_WIDTH + 4)'(byte_i[3:0]);

  // Decode of a byte that opens a new token.
  always_comb begin
    st_mode = stt_pkg::MODE_START;
    st_emit = 1'b0;
    st_kind = stt_pkg::KIND_DONE;
    st_byte = 8'd0;
    st_err  = stt_pkg::ERR_NONE;
    st_fail = 1'b0;
    st_line = 1'b0;
    st_num  = 1'b0;
    st_hash = 1'b0;
    unique case (byte_i) inside
      "\n":            st_line = 1'b1;
      " ", "\t", "\r": ;
      ".": begin st_emit = 1'b1; st_kind = stt_pkg::KIND_DOT;      end
      ";": begin st_emit = 1'b1; st_kind = stt_pkg::KIND_SEMI;     end
      "(": begin st_emit = 1'b1; st_kind = stt_pkg::KIND_LPAREN;   end
      ")": begin st_emit = 1'b1; st_kind = stt_pkg::KIND_RPAREN;   end
      ",": begin st_emit = 1'b1; st_kind = stt_pkg::KIND_COMMA;    end
      ":": begin st_emit = 1'b1; st_kind = stt_pkg::KIND_COLON;    end
      "?": begin st_emit = 1'b1; st_kind = stt_pkg::KIND_QUESTION; end
      "|": begin st_emit = 1'b1; st_kind = stt_pkg::KIND_BAR;      end
      "=": begin st_emit = 1'b1; st_kind = stt_pkg::KIND_EQUALS;   end
      "$": begin st_emit = 1'b1; st_kind = stt_pkg::KIND_DOLLAR;   end
      "&": begin st_emit = 1'b1; st_kind = stt_pkg::KIND_AMP;      end
      "-":  st_mode = stt_pkg::MODE_DASH;
      "#": begin
        st_mode = stt_pkg::MODE_HASH;
        st_hash = 1'b1;
      end
      "\"": st_mode = stt_pkg::MODE_STRING;
      "/":  st_mode = stt_pkg::MODE_SLASH;
      ["0":"9"]: begin
        st_mode = stt_pkg::MODE_NUMBER;
        st_num  = 1'b1;
      end
      ["a":"z"], ["A":"Z"]: begin
        st_mode = stt_pkg::MODE_IDENT;
        st_emit = 1'b1;
        st_kind = stt_pkg::KIND_TEXT_BYTE;
        st_byte = byte_i;
      end
      default: begin
        st_emit = 1'b1;
        st_fail = 1'b1;
        st_err  = stt_pkg::ERR_UNEXPECTED;
      end
    endcase
  end

  // First keyword that can take this byte after the prefix seen so far.
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = 3'd0;
    for (int k = stt_pkg::KW_COUNT - 1; k >= 0; k--) begin
      if (stt_pkg::kw_match(3'(k), cand_q, pos_q[2:0], byte_i)) begin
        kw_hit = 1'b1;
        kw_idx = 3'(k);
      end
    end
    kw_done = ({1'b0, pos_q[2:0]} + 4'd1) == stt_pkg::KW_LEN[kw_idx];
  end

  // One step of the scanner: next state and up to two results.
  always_comb begin
    mode_d     = mode_q;
    cand_d     = cand_q;
    pos_d      = pos_q;
    star_d     = star_q;
    acc_d      = acc_q;
    ovf_d      = ovf_q;
    lc_d       = lc_q;
    halt_d     = halt_q;
    do_start   = 1'b0;
    start_in_b = 1'b0;
    a_v        = 1'b0;
    b_v        = 1'b0;
    ra         = '0;
    rb         = '0;
    ra.line_number = 32'(ln_now);
    rb.line_number = 32'(ln_now);

    if (eot_i) begin
      // End of text: flush a pending token, report, then return to reset.
      a_v = 1'b1;
      if (!halt_q) begin
        case (mode_q)
          stt_pkg::MODE_NUMBER: begin
            ra.token_kind      = stt_pkg::KIND_NATURAL;
            ra.number_value    = 64'(acc_q);
            ra.number_overflow = ovf_q;
            b_v                = 1'b1;
          end
          stt_pkg::MODE_IDENT: begin
            ra.token_kind = stt_pkg::KIND_IDENT;
            b_v           = 1'b1;
          end
          stt_pkg::MODE_STRING: ra.error_code = stt_pkg::ERR_OPEN_STRING;
          stt_pkg::MODE_ESCAPE: ra.error_code = stt_pkg::ERR_BAD_ESCAPE;
          stt_pkg::MODE_BLOCK:  ra.error_code = stt_pkg::ERR_OPEN_COMMENT;
          stt_pkg::MODE_DASH,
          stt_pkg::MODE_HASH:   ra.error_code = stt_pkg::ERR_UNEXPECTED;
          default: ;
        endcase
      end
      mode_d = stt_pkg::MODE_START;
      cand_d = 3'd0;
      pos_d  = 4'd0;
      star_d = 1'b0;
      acc_d  = '0;
      ovf_d  = 1'b0;
      lc_d   = '0;
      halt_d = 1'b0;
    end else if (!halt_q) begin
      unique case (mode_q)
        stt_pkg::MODE_NUMBER: begin
          if (byte_i >= "0" && byte_i <= "9") begin
            acc_d = acc_wide[VALUE_WIDTH-1:0];
            if (|acc_wide[VALUE_WIDTH+3:VALUE_WIDTH]) begin
              ovf_d = 1'b1;
            end
          end else begin
            a_v                = 1'b1;
            ra.token_kind      = stt_pkg::KIND_NATURAL;
            ra.number_value    = 64'(acc_q);
            ra.number_overflow = ovf_q;
            do_start           = 1'b1;
            start_in_b         = 1'b1;
          end
        end
        stt_pkg::MODE_IDENT: begin
          a_v = 1'b1;
          if ((byte_i >= "0" && byte_i <= "9") || (byte_i >= "a" && byte_i <= "z") ||
              (byte_i >= "A" && byte_i <= "Z")) begin
            ra.token_kind = stt_pkg::KIND_TEXT_BYTE;
            ra.text_byte  = byte_i;
          end else begin
            ra.token_kind = stt_pkg::KIND_IDENT;
            do_start      = 1'b1;
            start_in_b    = 1'b1;
          end
        end
        stt_pkg::MODE_STRING: begin
          if (byte_i == "\"") begin
            a_v           = 1'b1;
            ra.token_kind = stt_pkg::KIND_STRING;
            mode_d        = stt_pkg::MODE_START;
          end else if (byte_i == "\\") begin
            mode_d = stt_pkg::MODE_ESCAPE;
          end else begin
            // A newline inside a string counts before its byte is reported.
            a_v           = 1'b1;
            ra.token_kind = stt_pkg::KIND_TEXT_BYTE;
            ra.text_byte  = byte_i;
            if (byte_i == "\n") begin
              lc_d           = lc_inc;
              ra.line_number = 32'(ln_inc);
            end
          end
        end
        stt_pkg::MODE_ESCAPE: begin
          a_v           = 1'b1;
          ra.token_kind = stt_pkg::KIND_TEXT_BYTE;
          mode_d        = stt_pkg::MODE_STRING;
          case (byte_i)
            "\\":    ra.text_byte = "\\";
            "n":     ra.text_byte = "\n";
            "r":     ra.text_byte = "\r";
            "\"":    ra.text_byte = "\"";
            "t":     ra.text_byte = "\t";
            default: begin
              ra.token_kind = stt_pkg::KIND_DONE;
              ra.error_code = stt_pkg::ERR_BAD_ESCAPE;
              halt_d        = 1'b1;
              mode_d        = stt_pkg::MODE_START;
            end
          endcase
        end
        stt_pkg::MODE_DASH: begin
          a_v    = 1'b1;
          mode_d = stt_pkg::MODE_START;
          if (byte_i == ">") begin
            ra.token_kind = stt_pkg::KIND_ARROW;
          end else begin
            ra.error_code = stt_pkg::ERR_UNEXPECTED;
            halt_d        = 1'b1;
          end
        end
        stt_pkg::MODE_HASH: begin
          if (kw_hit) begin
            if (kw_done) begin
              a_v           = 1'b1;
              ra.token_kind = stt_pkg::KIND_KW_FIRST + 5'(kw_idx);
              mode_d        = stt_pkg::MODE_START;
              cand_d        = 3'd0;
              pos_d         = 4'd0;
            end else begin
              cand_d = kw_idx;
              pos_d  = {1'b0, pos_q[2:0]} + 4'd1;
            end
          end else begin
            a_v           = 1'b1;
            ra.error_code = stt_pkg::ERR_UNEXPECTED;
            halt_d        = 1'b1;
            mode_d        = stt_pkg::MODE_START;
          end
        end
        stt_pkg::MODE_SLASH: begin
          if (byte_i == "/") begin
            mode_d = stt_pkg::MODE_LINE;
          end else if (byte_i == "*") begin
            mode_d = stt_pkg::MODE_BLOCK;
            star_d = 1'b0;
          end else begin
            // A lone slash is dropped and this byte opens a token.
            do_start = 1'b1;
          end
        end
        stt_pkg::MODE_LINE: begin
          if (byte_i == "\n") begin
            lc_d   = lc_inc;
            mode_d = stt_pkg::MODE_START;
          end
        end
        stt_pkg::MODE_BLOCK: begin
          if (star_q && byte_i == "/") begin
            star_d = 1'b0;
            mode_d = stt_pkg::MODE_START;
          end else begin
            if (byte_i == "\n") begin
              lc_d = lc_inc;
            end
            star_d = (byte_i == "*");
          end
        end
        default: do_start = 1'b1;
      endcase

      // Apply the start-of-token decode where this byte opens a token.
      if (do_start) begin
        mode_d = st_mode;
        if (st_line) begin
          lc_d = lc_inc;
        end
        if (st_num) begin
          acc_d = VALUE_WIDTH'(byte_i[3:0]);
          ovf_d = 1'b0;
        end
        if (st_hash) begin
          cand_d = 3'd0;
          pos_d  = 4'd0;
        end
        if (st_fail) begin
          halt_d = 1'b1;
        end
        if (st_emit) begin
          if (start_in_b) begin
            b_v           = 1'b1;
            rb.token_kind = st_kind;
            rb.text_byte  = st_byte;
            rb.error_code = st_err;
          end else begin
            a_v           = 1'b1;
            ra.token_kind = st_kind;
            ra.text_byte  = st_byte;
            ra.error_code = st_err;
          end
        end
      end
    end

    // Mark the final result of this step.
    if (b_v) begin
      rb.last = 1'b1;
    end else begin
      ra.last = 1'b1;
    end
  end

  assign res_a_valid_o = a_v;
  assign res_a_o       = ra;
  assign res_b_valid_o = b_v;
  assign res_b_o       = rb;

  // Scanner state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= stt_pkg::MODE_START;
      cand_q <= 3'd0;
      pos_q  <= 4'd0;
      star_q <= 1'b0;
      acc_q  <= '0;
      ovf_q  <= 1'b0;
      lc_q   <= '0;
      halt_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      cand_q <= cand_d;
      pos_q  <= pos_d;
      star_q <= star_d;
      acc_q  <= acc_d;
      ovf_q  <= ovf_d;
      lc_q   <= lc_d;
      halt_q <= halt_d;
    end
  end

endmodule

// ----- rtl/core/stt_result_fifo.sv -----
module stt_result_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             push_a_i,
  input  stt_pkg::result_t data_a_i,
  input  logic             push_b_i,
  input  stt_pkg::result_t data_b_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output stt_pkg::result_t data_o
);

  localparam int unsigned PtrW = stt_pkg::FIFO_PTR_W;
  localparam int unsigned CntW = stt_pkg::FIFO_CNT_W;

  stt_pkg::result_t mem_q [stt_pkg::FIFO_DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             pop;
  logic [CntW-1:0]  n_push;

  // Room for the two results that one step can make.
  assign room_o  = cnt_q <= CntW'(stt_pkg::FIFO_DEPTH - 2);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;

  assign n_push = push_i ? (CntW'(push_a_i) + CntW'(push_b_i)) : '0;
  assign wr_d   = wr_q + PtrW'(n_push);
  assign rd_d   = pop ? rd_q + PtrW'(1) : rd_q;
  assign cnt_d  = cnt_q + n_push - CntW'(pop);

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i && push_a_i) begin
      mem_q[wr_q] <= data_a_i;
    end
    if (push_i && push_b_i) begin
      mem_q[wr_q + PtrW'(1)] <= data_b_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/source_text_tokenizer_core.sv -----
// Streaming tokenizer for source text.
// The slave channel takes one source byte per transfer in s_axis_tdata; s_axis_tuser
// set marks end of text, and the byte is then ignored. The master channel gives one
// token or text byte per transfer: the kind in m_axis_tuser, the rest in m_axis_tdata,
// and m_axis_tlast on the last result that an input byte causes. A byte gives no,
// one or two results; end of text always gives at least the done or error result.
// The result of a byte passes through the input register, then one scanner step into
// the result queue, and only then appears on the master channel; a full queue can
// hold the step back.
// Throughput: one byte per cycle while bytes give at most one result each and the
// receiver takes each result; the single-read queue sends one result per cycle,
// so a byte that ends a natural or identifier and opens a token needs two transfers.
// Reset clears the scanner to the start of a token with line count zero and
// empties the result queue. When the receiver stalls, the queue (four results)
// fills, and s_axis_tready drops while a byte waits in the input register and fewer
// than two entries are free; nothing is lost. After an error, bytes are dropped
// until end of text, which returns the scanner to its reset state.
module source_text_tokenizer_core #(
  parameter int unsigned VALUE_WIDTH = stt_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned LINE_WIDTH  = stt_pkg::LINE_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] text_byte_in
  input  logic         s_axis_tuser,  // [0] end_of_text
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,  // [7:0] text_byte_out, [71:8] number_value,
                                      // [72] number_overflow, [104:73] line_number,
                                      // [107:105] error_code, [111:108] zero
  output logic [4:0]   m_axis_tuser,  // [4:0] token_kind
  output logic         m_axis_tlast
);

  logic             in_v_q, in_v_d;
  logic [7:0]       in_byte_q;
  logic             in_eot_q;
  logic             step;
  logic             room;
  logic             res_a_v, res_b_v;
  stt_pkg::result_t res_a, res_b;
  stt_pkg::result_t head;

  // The registered byte is scanned when the queue can take both possible results.
  assign step          = in_v_q && room;
  assign s_axis_tready = !in_v_q || step;
  assign in_v_d        = (s_axis_tvalid && s_axis_tready) || (in_v_q && !step);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eot_q  <= s_axis_tuser;
    end
  end

  stt_scanner #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .LINE_WIDTH  (LINE_WIDTH)
  ) u_scanner (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .byte_i        (in_byte_q),
    .eot_i         (in_eot_q),
    .res_a_valid_o (res_a_v),
    .res_a_o       (res_a),
    .res_b_valid_o (res_b_v),
    .res_b_o       (res_b)
  );

  stt_result_fifo u_result_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (step),
    .push_a_i (res_a_v),
    .data_a_i (res_a),
    .push_b_i (res_b_v),
    .data_b_i (res_b),
    .room_o   (room),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .data_o   (head)
  );

  // Pack the result at the head of the queue onto the master channel.
  assign m_axis_tdata = {4'b0000, head.error_code, head.line_number, head.number_overflow,
                         head.number_value, head.text_byte};
  assign m_axis_tuser = head.token_kind;
  assign m_axis_tlast = head.last;

endmodule
